// ----- design/bresenham_line_stepper_defines.svh -----
// ----------------------------------------------------------------------------
// Bresenham line stepper assertion macros
// Shared concurrent assertion forms used by the line stepper RTL.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bls_pkg.sv -----
// ----------------------------------------------------------------------------
// Bresenham line stepper package
// Widths, opcodes, word layouts and the line state record.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int COORD_BITS = 11;
  localparam int COLOR_BITS = 32;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;

  // input word layout, lowest bit first
  localparam int IN_XS_LSB    = 0;
  localparam int IN_YS_LSB    = IN_XS_LSB + COORD_BITS;
  localparam int IN_XE_LSB    = IN_YS_LSB + COORD_BITS;
  localparam int IN_YE_LSB    = IN_XE_LSB + COORD_BITS;
  localparam int IN_COL_LSB   = IN_YE_LSB + COORD_BITS;
  localparam int IN_FIELD_W   = IN_COL_LSB + COLOR_BITS;
  localparam int IN_DATA_W    = ((IN_FIELD_W + 7) / 8) * 8;

  localparam int OUT_FIELD_W  = 2 * COORD_BITS + COLOR_BITS;
  localparam int OUT_DATA_W   = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                       active;
    coord_t                     cur_x;
    coord_t                     cur_y;
    coord_t                     tgt_x;
    coord_t                     tgt_y;
    logic signed [ERR_BITS-1:0] err;
    logic                       x_dec;
    logic                       y_dec;
    logic [DELTA_BITS-1:0]      tdx;
    logic [DELTA_BITS-1:0]      tdy;
    logic                       x_major;
    logic [COLOR_BITS-1:0]      color;
  } line_state_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] color;
    coord_t                y;
    coord_t                x;
    logic                  last;
  } pixel_t;

endpackage

// ----- design/bls_setup.sv -----
// ----------------------------------------------------------------------------
// Bresenham line setup
// Derives directions, doubled deltas, major axis and initial error of a line.
// ----------------------------------------------------------------------------
module bls_setup (
  input  logic [bls_pkg::COORD_BITS-1:0] x_start,
  input  logic [bls_pkg::COORD_BITS-1:0] y_start,
  input  logic [bls_pkg::COORD_BITS-1:0] x_end,
  input  logic [bls_pkg::COORD_BITS-1:0] y_end,
  input  logic [bls_pkg::COLOR_BITS-1:0] draw_color,
  output bls_pkg::line_state_t           setup_state
);
  import bls_pkg::*;

  logic                       x_dec;
  logic                       y_dec;
  coord_t                     adx;
  coord_t                     ady;
  logic [DELTA_BITS-1:0]      tdx;
  logic [DELTA_BITS-1:0]      tdy;
  logic                       x_major;
  logic signed [ERR_BITS-1:0] err_init;

  always_comb begin
    x_dec   = x_end < x_start;
    y_dec   = y_end < y_start;
    adx     = x_dec ? (x_start - x_end) : (x_end - x_start);
    ady     = y_dec ? (y_start - y_end) : (y_end - y_start);
    tdx     = {adx, 1'b0};
    tdy     = {ady, 1'b0};
    // equal deltas fall to the y-major branch
    x_major = adx > ady;
    if (x_major) begin
      err_init = $signed(ERR_BITS'(tdy)) - $signed(ERR_BITS'(adx));
    end else begin
      err_init = $signed(ERR_BITS'(tdx)) - $signed(ERR_BITS'(ady));
    end

    setup_state.active  = 1'b1;
    setup_state.cur_x   = x_start;
    setup_state.cur_y   = y_start;
    setup_state.tgt_x   = x_end;
    setup_state.tgt_y   = y_end;
    setup_state.err     = err_init;
    setup_state.x_dec   = x_dec;
    setup_state.y_dec   = y_dec;
    setup_state.tdx     = tdx;
    setup_state.tdy     = tdy;
    setup_state.x_major = x_major;
    setup_state.color   = draw_color;
  end

endmodule

// ----- design/bls_step.sv -----
// ----------------------------------------------------------------------------
// Bresenham line step
// Produces the current pixel; steps one major-axis unit, or closes the line at its end.
// ----------------------------------------------------------------------------
module bls_step (
  input  bls_pkg::line_state_t cur_state,
  output bls_pkg::line_state_t next_state,
  output bls_pkg::pixel_t      pixel
);
  import bls_pkg::*;

  logic                       at_end;
  logic                       err_pos;
  logic [DELTA_BITS-1:0]      td_major;
  logic [DELTA_BITS-1:0]      td_minor;
  logic signed [ERR_BITS-1:0] err_sub;
  logic                       move_x;
  logic                       move_y;

  always_comb begin
    at_end   = cur_state.x_major ? (cur_state.cur_x == cur_state.tgt_x)
                                 : (cur_state.cur_y == cur_state.tgt_y);
    err_pos  = cur_state.err > $signed(ERR_BITS'(0));
    td_major = cur_state.x_major ? cur_state.tdx : cur_state.tdy;
    td_minor = cur_state.x_major ? cur_state.tdy : cur_state.tdx;
    err_sub  = err_pos ? $signed(ERR_BITS'(td_major)) : $signed(ERR_BITS'(0));
    // major axis always moves, minor axis only on positive error
    move_x   = cur_state.x_major | err_pos;
    move_y   = ~cur_state.x_major | err_pos;

    pixel.color = cur_state.color;
    pixel.last  = at_end;
    pixel.x     = at_end ? cur_state.tgt_x : cur_state.cur_x;
    pixel.y     = at_end ? cur_state.tgt_y : cur_state.cur_y;

    next_state = cur_state;
    if (at_end) begin
      next_state.active = 1'b0;
    end else begin
      next_state.err = cur_state.err - err_sub + $signed(ERR_BITS'(td_minor));
      if (move_x) begin
        next_state.cur_x = cur_state.x_dec ? (cur_state.cur_x - coord_t'(1))
                                           : (cur_state.cur_x + coord_t'(1));
      end
      if (move_y) begin
        next_state.cur_y = cur_state.y_dec ? (cur_state.cur_y - coord_t'(1))
                                           : (cur_state.cur_y + coord_t'(1));
      end
    end
  end

endmodule

// ----- design/bresenham_line_stepper.sv -----
// ----------------------------------------------------------------------------
// Bresenham line stepper
// Integer line rasteriser: one start word loads a line, each step word
// returns the next pixel of it.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : command words. in_tuser is the opcode (0 start, 1 step).
//           A start word loads both endpoints and the colour and returns
//           nothing; a start during a line drops that line.
//   out_* : pixel words, one per step word while a line is in progress.
//           out_tlast marks the end point, after which the line is closed.
//           A step word with no line in progress is consumed silently.
//   Latency: a pixel appears on out_* the cycle after its step word is
//   taken. Throughput: one word per cycle when not stalled; the whole step
//   is one pass of compare and add logic, line state to output register.
//   Stall: the output register holds while out_tready is low, and in_tready
//   drops only while that register is full and not being drained.
//   Reset: rst_n low for one edge closes any line and empties the output.
// ----------------------------------------------------------------------------
`include "bresenham_line_stepper_defines.svh"

module bresenham_line_stepper (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // in_tdata: x_start, y_start, x_end, y_end, draw_color, zero fill
  input  logic [bls_pkg::IN_DATA_W-1:0] in_tdata,
  // in_tuser: opcode
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_tdata: pixel_x, pixel_y, pixel_color, zero fill
  output logic [bls_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast
);
  import bls_pkg::*;

  line_state_t state_r;
  line_state_t setup_state;
  line_state_t step_state;
  pixel_t      step_pixel;
  pixel_t      pix_r;
  logic        out_valid_r;
  logic        in_fire;
  logic        step_fire;

  bls_setup u_setup (
    .x_start     (in_tdata[IN_XS_LSB +: COORD_BITS]),
    .y_start     (in_tdata[IN_YS_LSB +: COORD_BITS]),
    .x_end       (in_tdata[IN_XE_LSB +: COORD_BITS]),
    .y_end       (in_tdata[IN_YE_LSB +: COORD_BITS]),
    .draw_color  (in_tdata[IN_COL_LSB +: COLOR_BITS]),
    .setup_state (setup_state)
  );

  bls_step u_step (
    .cur_state  (state_r),
    .next_state (step_state),
    .pixel      (step_pixel)
  );

  assign in_tready = ~out_valid_r | out_tready;
  assign in_fire   = in_tvalid & in_tready;
  assign step_fire = in_fire & (in_tuser == OP_STEP) & state_r.active;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.active <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_fire && (in_tuser == OP_START)) begin
        state_r <= setup_state;
      end else if (step_fire) begin
        state_r <= step_state;
      end
      // load a fresh pixel word, or drop the one just taken
      if (step_fire) begin
        out_valid_r <= 1'b1;
        pix_r       <= step_pixel;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = pix_r.last;
  assign out_tdata  = OUT_DATA_W'({pix_r.color, pix_r.y, pix_r.x});

  `BLS_ASSERT_NEXT(a_start_opens, clk, rst_n,
    in_fire && (in_tuser == OP_START), state_r.active, "start did not open a line")
  `BLS_ASSERT_NEXT(a_last_closes, clk, rst_n,
    step_fire && step_pixel.last, !state_r.active, "end point left the line open")
  `BLS_ASSERT_NEXT(a_idle_step_silent, clk, rst_n,
    in_fire && (in_tuser == OP_STEP) && !state_r.active && out_tready, !out_valid_r,
    "step with no line produced a word")
  `BLS_ASSERT_NEXT(a_major_x_moves, clk, rst_n,
    step_fire && !step_pixel.last && state_r.x_major,
    state_r.cur_x != $past(state_r.cur_x), "x-major step did not move x")
  `BLS_ASSERT_NEXT(a_major_y_moves, clk, rst_n,
    step_fire && !step_pixel.last && !state_r.x_major,
    state_r.cur_y != $past(state_r.cur_y), "y-major step did not move y")

endmodule

// ----- bench/tb_bresenham_line_stepper.sv -----
// ----------------------------------------------------------------------------
// Bresenham line stepper testbench
// Drives start and step words into the stepper with random gaps. Each pixel
// word that comes out is checked against a behavioural line predictor. Also
// covers a long output hold-off, a stretch with no gaps and drained pauses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bresenham_line_stepper;
  import bls_pkg::*;

  localparam int MAX_COORD   = (1 << COORD_BITS) - 1;
  localparam int HOLD_CYCLES = 60;
  localparam int IDLE_PCT    = 34;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  // predictor copy of the line state
  bit            ln_active;
  coord_t        ln_x;
  coord_t        ln_y;
  coord_t        ln_tx;
  coord_t        ln_ty;
  int            ln_err;
  bit            ln_xdec;
  bit            ln_ydec;
  int            ln_tdx;
  int            ln_tdy;
  bit            ln_xmajor;
  logic [31:0]   ln_color;

  pixel_t        pending_pixels[$];
  pixel_t        want_px;
  int            mismatch_count = 0;
  int            words_sent;
  bit            gaps_on;
  bit            stall_on;
  int            hold_reqs = 0;
  int            holds_done = 0;

  bresenham_line_stepper DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("bresenham_line_stepper regression: fail");
    $finish;
  end

  // work out the pixel, if any, that one accepted word produces
  task automatic predict_pixel(logic op, coord_t xs, coord_t ys, coord_t xe, coord_t ye,
                               logic [31:0] col);
    int     adx;
    int     ady;
    pixel_t px;
    if (op == OP_START) begin
      ln_xdec   = xe < xs;
      ln_ydec   = ye < ys;
      adx       = ln_xdec ? int'(xs) - int'(xe) : int'(xe) - int'(xs);
      ady       = ln_ydec ? int'(ys) - int'(ye) : int'(ye) - int'(ys);
      ln_tdx    = 2 * adx;
      ln_tdy    = 2 * ady;
      ln_xmajor = adx > ady;
      ln_err    = ln_xmajor ? ln_tdy - adx : ln_tdx - ady;
      ln_x      = xs;
      ln_y      = ys;
      ln_tx     = xe;
      ln_ty     = ye;
      ln_color  = col;
      ln_active = 1'b1;
    end else if (ln_active) begin
      px.color = ln_color;
      if (ln_xmajor ? (ln_x == ln_tx) : (ln_y == ln_ty)) begin
        // end point is always exact, whatever the error term says
        px.x      = ln_tx;
        px.y      = ln_ty;
        px.last   = 1'b1;
        ln_active = 1'b0;
      end else begin
        px.x    = ln_x;
        px.y    = ln_y;
        px.last = 1'b0;
        if (ln_xmajor) begin
          if (ln_err > 0) begin
            ln_y   = ln_ydec ? ln_y - coord_t'(1) : ln_y + coord_t'(1);
            ln_err = ln_err - ln_tdx;
          end
          ln_err = ln_err + ln_tdy;
          ln_x   = ln_xdec ? ln_x - coord_t'(1) : ln_x + coord_t'(1);
        end else begin
          if (ln_err > 0) begin
            ln_x   = ln_xdec ? ln_x - coord_t'(1) : ln_x + coord_t'(1);
            ln_err = ln_err - ln_tdy;
          end
          ln_err = ln_err + ln_tdx;
          ln_y   = ln_ydec ? ln_y - coord_t'(1) : ln_y + coord_t'(1);
        end
      end
      pending_pixels.push_back(px);
    end
  endtask

  // offer one word; valid stays high on return so the next word can follow
  task automatic send_word(logic op, coord_t xs, coord_t ys, coord_t xe, coord_t ye,
                           logic [31:0] col);
    if (gaps_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - IN_FIELD_W){1'b0}}, col, ye, xe, ys, xs};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    predict_pixel(op, xs, ys, xe, ye, col);
  endtask

  task automatic send_step();
    send_word(OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), $urandom);
  endtask

  // drop valid and hold until every predicted pixel has arrived
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  task automatic run_line(coord_t xs, coord_t ys, coord_t xe, coord_t ye,
                          logic [31:0] col, int steps);
    send_word(OP_START, xs, ys, xe, ye, col);
    repeat (steps) send_step();
  endtask

  function automatic int line_pixels(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    int adx;
    int ady;
    adx = (xe > xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
    ady = (ye > ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
    return ((adx > ady) ? adx : ady) + 1;
  endfunction

  function automatic coord_t near_coord(coord_t c);
    int v;
    v = int'(c) + $urandom_range(48) - 24;
    if (v < 0) v = 0;
    if (v > MAX_COORD) v = MAX_COORD;
    return coord_t'(v);
  endfunction

  // one random line: mostly short and run to the end, sometimes cut short,
  // overrun into idle steps, or a full-range line dropped by the next start
  task automatic random_line();
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
    int     len;
    int     r;
    int     steps;
    xs = coord_t'($urandom);
    ys = coord_t'($urandom);
    if ($urandom_range(99) < 10) begin
      xe = coord_t'($urandom);
      ye = coord_t'($urandom);
    end else begin
      xe = near_coord(xs);
      ye = near_coord(ys);
    end
    len = line_pixels(xs, ys, xe, ye);
    r   = $urandom_range(99);
    if (len > 50)
      steps = $urandom_range(1, 30);
    else if (r < 10)
      steps = $urandom_range(0, len - 1);
    else if (r < 20)
      steps = len + $urandom_range(1, 3);
    else
      steps = len;
    run_line(xs, ys, xe, ye, $urandom, steps);
  endtask

  task automatic test_idle_steps();
    send_step();
    send_step();
  endtask

  task automatic test_directed();
    // single point, then a step with nothing in progress
    run_line(11'd7, 11'd9, 11'd7, 11'd9, 32'h0000_0000, 2);
    // full diagonals both ways; each later start drops the line before it
    run_line(11'd0, 11'd0, 11'd2047, 11'd2047, 32'hFFFF_FFFF, 3);
    run_line(11'd2047, 11'd2047, 11'd0, 11'd0, 32'h0000_0001, 2);
    run_line(11'd2047, 11'd0, 11'd0, 11'd2047, 32'hA5A5_5A5A, 2);
    // x-major with y falling, run to its end
    run_line(11'd2, 11'd3, 11'd6, 11'd1, 32'h8000_0000, 5);
    // horizontal along the top edge
    run_line(11'd0, 11'd2047, 11'd3, 11'd2047, 32'h5A5A_A5A5, 4);
  endtask

  task automatic test_random_lines(int n_words);
    int stop_at;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 3)
        send_step();
      else
        random_line();
      if ($urandom_range(99) < 2)
        wait_drain();
    end
  endtask

  task automatic test_no_gaps();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    test_random_lines(100);
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_output_hold();
    wait_drain();
    hold_reqs++;
    // keep offering steps so the output fills and input backs up
    run_line(11'd100, 11'd40, 11'd130, 11'd52, $urandom, 31);
    wait_drain();
  endtask

  // receiver: random stalls, plus a counted hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        out_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        holds_done  = hold_reqs;
        out_tready <= 1'b1;
      end else begin
        out_tready <= !stall_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel: expected none, actual x=%0d y=%0d col=%h last=%b",
                 $time, out_tdata[10:0], out_tdata[21:11], out_tdata[53:22], out_tlast);
        mismatch_count++;
      end else begin
        want_px = pending_pixels.pop_front();
        if (out_tdata[10:0] !== want_px.x) begin
          $display("%0t: pixel_x expected %0d actual %0d", $time, want_px.x, out_tdata[10:0]);
          mismatch_count++;
        end
        if (out_tdata[21:11] !== want_px.y) begin
          $display("%0t: pixel_y expected %0d actual %0d", $time, want_px.y,
                   out_tdata[21:11]);
          mismatch_count++;
        end
        if (out_tdata[53:22] !== want_px.color) begin
          $display("%0t: pixel_color expected %h actual %h", $time, want_px.color,
                   out_tdata[53:22]);
          mismatch_count++;
        end
        if (out_tlast !== want_px.last) begin
          $display("%0t: last_pixel expected %b actual %b", $time, want_px.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = OP_STEP;
    ln_active      = 1'b0;
    words_sent     = 0;
    gaps_on        = 1'b1;
    stall_on       = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_steps();
    test_directed();
    test_output_hold();
    test_random_lines(1100);
    test_no_gaps();
    test_output_hold();
    test_random_lines(100);

    stall_on = 1'b0;
    wait_drain();
    // catch any stray pixel after the last one predicted
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("bresenham_line_stepper regression: pass");
    else
      $display("bresenham_line_stepper regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/bls_pkg.sv
design/bls_setup.sv
design/bls_step.sv
design/bresenham_line_stepper.sv
bench/tb_bresenham_line_stepper.sv
